// ===== rtl/lbt_pkg.sv =====
`timescale 1ns / 1ps

package lbt_pkg;

    localparam int NODE_BITS  = 6;
    localparam int NODE_COUNT = 1 << NODE_BITS;
    localparam int FAN_BITS   = 8;
    localparam int ENT_BITS   = NODE_BITS + FAN_BITS;
    localparam int VAL_BITS   = 32;
    localparam int KEY_BITS   = 32;
    localparam int KEY_BYTES_MAX = 4;
    localparam int LEN_MAX    = 8 * KEY_BYTES_MAX;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [ENT_BITS-1:0]  ent_addr_t;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_LOOKUP   = 2'd1,
        OP_DELETE   = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    localparam logic CFG_KEY_BYTES    = 1'b0;
    localparam logic CFG_AUTO_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LK_PROBE,
        ST_LK_NEXT,
        ST_WALK,
        ST_WCHK,
        ST_INS_CHK,
        ST_ALLOC_RD,
        ST_ALLOC_WR,
        ST_SLOT_RD,
        ST_SLOT_WR,
        ST_REL_RD,
        ST_REL_CHK,
        ST_REL_PW,
        ST_RESP
    } state_t;

    // byte i of the key, byte 0 most significant; beyond the key reads zero
    function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] k,
                                            input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = k[31:24];
            3'd1:    b = k[23:16];
            3'd2:    b = k[15:8];
            3'd3:    b = k[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // slot for a remainder of rem bits taken from the top of b
    function automatic logic [7:0] slot_index(input logic [2:0] rem,
                                              input logic [7:0] b);
        logic [8:0] base;
        logic [7:0] top;
        base = (9'd1 << rem) - 9'd1;
        top  = b >> (4'd8 - {1'b0, rem});
        if (rem == 3'd0)
            return 8'd0;
        return base[7:0] + top;
    endfunction

endpackage

// ===== rtl/lpm_byte_trie_engine.sv =====
`timescale 1ns / 1ps

// Longest-prefix-match engine on a byte-stride trie with a 64-node pool. Per
// node: 256 child links and 255 prefix slots, both in single-port synchronous
// memories with registered reads, plus small per-node count memories and a
// free-node stack. One transaction is handled at a time; the output register
// lets a new transaction enter while the previous result waits. The one
// slot-memory read port sets the pace: lookup makes 8 slot probes per level
// short of the key depth and one at that depth, child link read overlapped;
// insert walks the existing levels, allocates missing nodes, then reads and
// writes the slot; delete walks, clears the slot and, with auto-release set,
// frees each emptied node upward. After reset a clearing pass sweeps the link
// and slot memories, the branch and prefix counts and the free stack; in_stall
// stays high through it, configuration writes are taken.
module lpm_byte_trie_engine
    import lbt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [2:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [KEY_BITS-1:0] key,
    input  logic [5:0]          prefix_len,
    input  logic [VAL_BITS-1:0] entry_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [VAL_BITS-1:0] result_value,
    output logic                status
);

    // memories
    node_t                 child_mem  [1<<ENT_BITS];
    logic [VAL_BITS:0]     slot_mem   [1<<ENT_BITS];
    node_t                 parent_mem [NODE_COUNT];
    logic [7:0]            label_mem  [NODE_COUNT];
    logic [8:0]            branch_mem [NODE_COUNT];
    logic [7:0]            pcnt_mem   [NODE_COUNT];
    node_t                 free_mem   [NODE_COUNT];

    logic child_we, child_re, slot_we, slot_re;
    ent_addr_t child_wa, child_ra, slot_wa, slot_ra;
    node_t child_wd, child_rd;
    logic [VAL_BITS:0] slot_wd, slot_rd;
    logic parent_we, label_we, branch_we, branch_re, pcnt_we, pcnt_re;
    logic node_re, free_we, free_re;
    node_t parent_wa, branch_wa, branch_ra, pcnt_wa, pcnt_ra, node_ra;
    node_t free_wa, free_ra, free_wd, free_rd, parent_wd, parent_rd;
    logic [7:0] label_wd, label_rd, pcnt_wd, pcnt_rd;
    logic [8:0] branch_wd, branch_rd;

    always_ff @(posedge clk)
    begin
        if (child_we) child_mem[child_wa] <= child_wd;
        if (child_re) child_rd <= child_mem[child_ra];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        if (slot_re) slot_rd <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (parent_we) parent_mem[parent_wa] <= parent_wd;
        if (label_we) label_mem[parent_wa] <= label_wd;
        if (node_re)
        begin
            parent_rd <= parent_mem[node_ra];
            label_rd  <= label_mem[node_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (branch_we) branch_mem[branch_wa] <= branch_wd;
        if (branch_re) branch_rd <= branch_mem[branch_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pcnt_we) pcnt_mem[pcnt_wa] <= pcnt_wd;
        if (pcnt_re) pcnt_rd <= pcnt_mem[pcnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (free_we) free_mem[free_wa] <= free_wd;
        if (free_re) free_rd <= free_mem[free_ra];
    end

    // control and working registers
    state_t state_reg, state_next;
    logic [ENT_BITS-1:0] clr_reg, clr_next;
    logic [6:0] free_cnt_reg, free_cnt_next;
    logic [2:0] key_bytes_reg;
    logic       auto_rel_reg;
    logic       out_valid_reg, out_valid_next;
    logic       found_reg, found_next, status_reg, status_next;
    logic [VAL_BITS-1:0] value_reg, value_next;
    logic       chk_reg, chk_next, hit_reg, hit_next;
    logic [VAL_BITS-1:0] best_reg, best_next;

    // per-transaction payload
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VAL_BITS-1:0] val_reg, val_next;
    logic [2:0] nbytes_reg, nbytes_next, rem_reg, rem_next;
    logic [2:0] lvl_reg, lvl_next, l_reg, l_next, need_reg, need_next;
    logic [2:0] levels_reg, levels_next;
    node_t      node_reg, node_next;
    logic       res_found_reg, res_found_next, res_status_reg, res_status_next;
    logic [VAL_BITS-1:0] res_value_reg, res_value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_cnt_reg  <= 7'(NODE_COUNT - 1);
            key_bytes_reg <= 3'd4;
            auto_rel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
            chk_reg       <= chk_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_BYTES:    key_bytes_reg <= cfg_data;
                    CFG_AUTO_RELEASE: auto_rel_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg      <= found_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        hit_reg        <= hit_next;
        best_reg       <= best_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        nbytes_reg     <= nbytes_next;
        rem_reg        <= rem_next;
        lvl_reg        <= lvl_next;
        l_reg          <= l_next;
        need_reg       <= need_next;
        levels_reg     <= levels_next;
        node_reg       <= node_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign result_value = value_reg;
    assign status       = status_reg;

    // probe result from the previous cycle's slot read, plus key and stack helpers
    logic                hit_cur;
    logic [VAL_BITS-1:0] best_cur;
    logic [7:0]          cur_byte;
    logic [5:0]          len_sat;
    logic [2:0]          lmax;
    node_t               free_top;

    always_comb
    begin
        hit_cur  = hit_reg;
        best_cur = best_reg;
        if (chk_reg && slot_rd[VAL_BITS])
        begin
            hit_cur  = 1'b1;
            best_cur = slot_rd[VAL_BITS-1:0];
        end
        cur_byte = key_byte(key_reg, lvl_reg);
        len_sat  = (prefix_len > 6'(LEN_MAX)) ? 6'(LEN_MAX) : prefix_len;
        lmax     = (lvl_reg < levels_reg) ? 3'd7 : 3'd0;
        free_top = NODE_BITS'(free_cnt_reg - 7'd1);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        free_cnt_next   = free_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        found_next      = found_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        chk_next        = 1'b0;
        hit_next        = hit_cur;
        best_next       = best_cur;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        nbytes_next     = nbytes_reg;
        rem_next        = rem_reg;
        lvl_next        = lvl_reg;
        l_next          = l_reg;
        need_next       = need_reg;
        levels_next     = levels_reg;
        node_next       = node_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;

        child_we = 1'b0; child_re = 1'b0; child_wa = '0; child_ra = '0; child_wd = '0;
        slot_we  = 1'b0; slot_re  = 1'b0; slot_wa  = '0; slot_ra  = '0; slot_wd  = '0;
        parent_we = 1'b0; label_we = 1'b0; parent_wa = '0; parent_wd = '0; label_wd = '0;
        node_re  = 1'b0; node_ra = '0;
        branch_we = 1'b0; branch_re = 1'b0; branch_wa = '0; branch_ra = '0;
        branch_wd = '0;
        pcnt_we  = 1'b0; pcnt_re = 1'b0; pcnt_wa = '0; pcnt_ra = '0; pcnt_wd = '0;
        free_we  = 1'b0; free_re = 1'b0; free_wa = '0; free_ra = '0; free_wd = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep one entry a cycle; node tables ride on the low addresses
                child_we = 1'b1;
                child_wa = clr_reg;
                slot_we  = 1'b1;
                slot_wa  = clr_reg;
                if (clr_reg[ENT_BITS-1:NODE_BITS] == '0)
                begin
                    branch_we = 1'b1;
                    branch_wa = clr_reg[NODE_BITS-1:0];
                    pcnt_we   = 1'b1;
                    pcnt_wa   = clr_reg[NODE_BITS-1:0];
                    free_we   = 1'b1;
                    free_wa   = clr_reg[NODE_BITS-1:0];
                    free_wd   = ~clr_reg[NODE_BITS-1:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    key_next    = key;
                    val_next    = entry_value;
                    nbytes_next = len_sat[5:3];
                    rem_next    = len_sat[2:0];
                    node_next   = '0;
                    lvl_next    = '0;
                    l_next      = '0;
                    hit_next    = 1'b0;
                    best_next   = '0;
                    levels_next = (key_bytes_reg > 3'(KEY_BYTES_MAX)) ?
                                  3'(KEY_BYTES_MAX) : key_bytes_reg;
                    res_found_next  = 1'b0;
                    res_status_next = 1'b0;
                    res_value_next  = '0;
                    case (op)
                        OP_INSERT: state_next = ST_WALK;
                        OP_DELETE: state_next = ST_WALK;
                        OP_LOOKUP: state_next = ST_LK_PROBE;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end

            ST_LK_PROBE:
            begin
                // slots probed shallow to deep, so the deepest valid one wins
                slot_re  = 1'b1;
                slot_ra  = {node_reg, slot_index(l_reg, cur_byte)};
                chk_next = 1'b1;
                if (l_reg == 3'd0 && lvl_reg < levels_reg)
                begin
                    child_re = 1'b1;
                    child_ra = {node_reg, cur_byte};
                end
                if (l_reg == lmax)
                    state_next = ST_LK_NEXT;
                else
                    l_next = l_reg + 3'd1;
            end

            ST_LK_NEXT:
            begin
                if (lvl_reg >= levels_reg || child_rd == '0)
                begin
                    res_found_next = hit_cur;
                    res_value_next = hit_cur ? best_cur : '0;
                    state_next     = ST_RESP;
                end
                else
                begin
                    node_next  = child_rd;
                    lvl_next   = lvl_reg + 3'd1;
                    l_next     = '0;
                    state_next = ST_LK_PROBE;
                end
            end

            ST_WALK:
            begin
                if (lvl_reg == nbytes_reg)
                begin
                    need_next  = '0;
                    state_next = (op_reg == OP_INSERT) ? ST_INS_CHK : ST_SLOT_RD;
                end
                else
                begin
                    child_re   = 1'b1;
                    child_ra   = {node_reg, cur_byte};
                    state_next = ST_WCHK;
                end
            end

            ST_WCHK:
            begin
                if (child_rd == '0)
                begin
                    need_next  = nbytes_reg - lvl_reg;
                    state_next = (op_reg == OP_INSERT) ? ST_INS_CHK : ST_RESP;
                end
                else
                begin
                    node_next  = child_rd;
                    lvl_next   = lvl_reg + 3'd1;
                    state_next = ST_WALK;
                end
            end

            ST_INS_CHK:
            begin
                if ({4'd0, need_reg} > free_cnt_reg)
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_RESP;
                end
                else if (need_reg != '0)
                    state_next = ST_ALLOC_RD;
                else
                    state_next = ST_SLOT_RD;
            end

            ST_ALLOC_RD:
            begin
                free_re    = 1'b1;
                free_ra    = free_top;
                branch_re  = 1'b1;
                branch_ra  = node_reg;
                state_next = ST_ALLOC_WR;
            end

            ST_ALLOC_WR:
            begin
                parent_we     = 1'b1;
                label_we      = 1'b1;
                parent_wa     = free_rd;
                parent_wd     = node_reg;
                label_wd      = cur_byte;
                child_we      = 1'b1;
                child_wa      = {node_reg, cur_byte};
                child_wd      = free_rd;
                branch_we     = 1'b1;
                branch_wa     = node_reg;
                branch_wd     = branch_rd + 9'd1;
                free_cnt_next = free_cnt_reg - 7'd1;
                node_next     = free_rd;
                lvl_next      = lvl_reg + 3'd1;
                state_next    = (lvl_reg + 3'd1 == nbytes_reg) ? ST_SLOT_RD : ST_ALLOC_RD;
            end

            ST_SLOT_RD:
            begin
                slot_re    = 1'b1;
                slot_ra    = {node_reg, slot_index(rem_reg, key_byte(key_reg, nbytes_reg))};
                pcnt_re    = 1'b1;
                pcnt_ra    = node_reg;
                state_next = ST_SLOT_WR;
            end

            ST_SLOT_WR:
            begin
                slot_wa = {node_reg, slot_index(rem_reg, key_byte(key_reg, nbytes_reg))};
                pcnt_wa = node_reg;
                if (op_reg == OP_INSERT)
                begin
                    slot_we        = 1'b1;
                    slot_wd        = {1'b1, val_reg};
                    res_found_next = slot_rd[VAL_BITS];
                    res_value_next = slot_rd[VAL_BITS] ? slot_rd[VAL_BITS-1:0] : '0;
                    if (!slot_rd[VAL_BITS])
                    begin
                        pcnt_we = 1'b1;
                        pcnt_wd = pcnt_rd + 8'd1;
                    end
                    state_next = ST_RESP;
                end
                else if (!slot_rd[VAL_BITS])
                    state_next = ST_RESP;
                else
                begin
                    slot_we        = 1'b1;
                    slot_wd        = '0;
                    pcnt_we        = 1'b1;
                    pcnt_wd        = (pcnt_rd != 8'd0) ? pcnt_rd - 8'd1 : 8'd0;
                    res_found_next = 1'b1;
                    res_value_next = slot_rd[VAL_BITS-1:0];
                    state_next     = auto_rel_reg ? ST_REL_RD : ST_RESP;
                end
            end

            ST_REL_RD:
            begin
                if (node_reg == '0)
                    state_next = ST_RESP;
                else
                begin
                    pcnt_re    = 1'b1;
                    pcnt_ra    = node_reg;
                    branch_re  = 1'b1;
                    branch_ra  = node_reg;
                    node_re    = 1'b1;
                    node_ra    = node_reg;
                    state_next = ST_REL_CHK;
                end
            end

            ST_REL_CHK:
            begin
                if (pcnt_rd != 8'd0 || branch_rd != 9'd0)
                    state_next = ST_RESP;
                else
                begin
                    // unlink from the parent and push the node back on the stack
                    child_we  = 1'b1;
                    child_wa  = {parent_rd, label_rd};
                    child_wd  = '0;
                    branch_re = 1'b1;
                    branch_ra = parent_rd;
                    if (free_cnt_reg < 7'(NODE_COUNT))
                    begin
                        free_we       = 1'b1;
                        free_wa       = free_cnt_reg[NODE_BITS-1:0];
                        free_wd       = node_reg;
                        free_cnt_next = free_cnt_reg + 7'd1;
                    end
                    node_next  = parent_rd;
                    state_next = ST_REL_PW;
                end
            end

            ST_REL_PW:
            begin
                branch_we  = 1'b1;
                branch_wa  = node_reg;
                branch_wd  = (branch_rd != 9'd0) ? branch_rd - 9'd1 : 9'd0;
                state_next = ST_REL_RD;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    value_next     = res_value_reg;
                    status_next    = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // pool never holds more than the non-root nodes
    assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= 7'(NODE_COUNT - 1))
        else $error("free node count above pool size");

    // a new result appears only out of the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result without response state");

    // a lookup never modifies the slot memory
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LK_PROBE || state_reg == ST_LK_NEXT) |-> !slot_we)
        else $error("slot write during lookup");

    // no transaction is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (in_stall || $past(clr_reg == '1)))
        else $error("input taken during clearing pass");

endmodule
